[sv/ole_pkg.sv]
// Shared types and codes for the ordered list engine.
// Used by ole_cell, ordered_list_engine_core, ole_checker and the bench; no dependencies.
package ole_pkg;

    localparam int VAL_W = 32;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_READ   = 2'd1;
    localparam t_mode MODE_DELETE = 2'd2;
    localparam t_mode MODE_FIND   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_RANGE    = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    typedef logic [2:0] t_cell_op;
    localparam t_cell_op OP_NOP    = 3'd0;
    localparam t_cell_op OP_INSERT = 3'd1;
    localparam t_cell_op OP_DELETE = 3'd2;
    localparam t_cell_op OP_READ   = 3'd3;
    localparam t_cell_op OP_FIND   = 3'd4;

    typedef struct packed {
        t_cell_op          op;
        logic [VAL_W-1:0]  key;
    } t_cell_cmd;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [VAL_W-1:0]  data;
    } t_token;

endpackage

[sv/ole_cell.sv]
// One list slot: holds an entry, shifts with its neighbors, latches a hit
// flag and forwards the scan token. Depends on ole_pkg.
module ole_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int IW  = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ole_pkg::t_cell_cmd        i_cmd,
    input  logic [CW-1:0]             i_pos,
    input  logic [CW-1:0]             i_count,
    input  logic [ole_pkg::VAL_W-1:0] i_left,
    input  logic [ole_pkg::VAL_W-1:0] i_right,
    output logic [ole_pkg::VAL_W-1:0] o_val,
    input  ole_pkg::t_token           i_tok,
    input  logic [IW-1:0]             i_tok_pos,
    output ole_pkg::t_token           o_tok,
    output logic [IW-1:0]             o_tok_pos
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [ole_pkg::VAL_W-1:0] r_val;
    logic                      r_hit;
    ole_pkg::t_token           r_tok;
    logic [IW-1:0]             r_tok_pos;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ole_pkg::OP_INSERT: begin
                if (MY_IDX > i_pos) begin
                    r_val <= i_left;
                end else if (MY_IDX == i_pos) begin
                    r_val <= i_cmd.key;
                end
            end
            ole_pkg::OP_DELETE: begin
                if (MY_IDX >= i_pos) begin
                    r_val <= i_right;
                end
            end
            ole_pkg::OP_READ: begin
                r_hit <= (MY_IDX == i_pos);
            end
            ole_pkg::OP_FIND: begin
                r_hit <= (MY_IDX < i_count) && (r_val == i_cmd.key);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        if (i_tok.valid && !i_tok.found && r_hit) begin
            r_tok.found <= 1'b1;
            r_tok.data  <= r_val;
            r_tok_pos   <= IW'(IDX);
        end else begin
            r_tok.found <= i_tok.found;
            r_tok.data  <= i_tok.data;
            r_tok_pos   <= i_tok_pos;
        end
    end

    assign o_val     = r_val;
    assign o_tok     = r_tok;
    assign o_tok_pos = r_tok_pos;

endmodule

[sv/ordered_list_engine_core.sv]
// Ordered list engine top level: request decode, entry count, cell row and
// result register. Depends on ole_pkg and ole_cell.
//
//  channel   | dir | tdata (low bit up)                 | tuser
//  s_axis    | in  | position, value, zero pad          | mode
//  m_axis    | out | read_value, found_position, count  | status
//
// Insert, delete and rejected requests: result registered on accept, shown in the next cycle.
// Read and find: result set by the scan token walking the cell row, one cell per cycle,
// then registered in the result register; one request at a time.
// Reset clears the count and the handshake state; entries need no clearing.
// A new request is taken only while no scan runs and once the previous result has left or leaves now.
module ordered_list_engine_core #(
    parameter int DEPTH = 16,
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int IW     = $clog2(DEPTH),
    localparam int VW     = ole_pkg::VAL_W,
    localparam int IN_W   = CW + VW,
    localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = VW + IW + CW,
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // position, value, zero pad
    input  logic [IN_DW-1:0]  i_s_axis_tdata,
    // mode
    input  logic [1:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // read_value, found_position, entry_count, zero pad
    output logic [OUT_DW-1:0] o_m_axis_tdata,
    // status
    output logic [1:0]    o_m_axis_tuser
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [0:0]          r_state;
    logic                r_first;
    logic                r_is_find;
    logic [CW-1:0]       r_count;
    logic                r_out_valid;
    ole_pkg::t_status    r_out_status;
    logic [VW-1:0]       r_out_data;
    logic [IW-1:0]       r_out_fpos;
    logic [CW-1:0]       r_out_count;

    ole_pkg::t_mode      w_mode;
    logic [CW-1:0]       w_pos;
    logic [VW-1:0]       w_key;
    logic                w_accept;
    ole_pkg::t_cell_op   w_op;
    ole_pkg::t_status    w_status;
    logic [CW-1:0]       n_count;
    logic                w_scan;
    ole_pkg::t_cell_cmd  w_cmd;

    logic [VW-1:0]       w_val [DEPTH];
    ole_pkg::t_token     w_tok [DEPTH+1];
    logic [IW-1:0]       w_tok_pos [DEPTH+1];

    assign w_mode   = i_s_axis_tuser;
    assign w_pos    = i_s_axis_tdata[CW-1:0];
    assign w_key    = i_s_axis_tdata[CW+VW-1:CW];
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_op     = ole_pkg::OP_NOP;
        w_status = ole_pkg::ST_OK;
        n_count  = r_count;
        w_scan   = 1'b0;
        unique case (w_mode)
            ole_pkg::MODE_INSERT: begin
                if (w_pos > r_count) begin
                    w_status = ole_pkg::ST_RANGE;
                end else if (r_count == CW'(DEPTH)) begin
                    w_status = ole_pkg::ST_FULL;
                end else begin
                    w_op    = ole_pkg::OP_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            ole_pkg::MODE_READ: begin
                if (w_pos >= r_count) begin
                    w_status = ole_pkg::ST_RANGE;
                end else begin
                    w_op   = ole_pkg::OP_READ;
                    w_scan = 1'b1;
                end
            end
            ole_pkg::MODE_DELETE: begin
                if (w_pos >= r_count) begin
                    w_status = ole_pkg::ST_RANGE;
                end else begin
                    w_op    = ole_pkg::OP_DELETE;
                    n_count = r_count - CW'(1);
                end
            end
            ole_pkg::MODE_FIND: begin
                if (r_count == '0) begin
                    w_status = ole_pkg::ST_NOTFOUND;
                end else begin
                    w_op   = ole_pkg::OP_FIND;
                    w_scan = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_cmd.op  = w_accept ? w_op : ole_pkg::OP_NOP;
    assign w_cmd.key = w_key;

    assign w_tok[0].valid = (r_state == S_SCAN) && r_first;
    assign w_tok[0].found = 1'b0;
    assign w_tok[0].data  = '0;
    assign w_tok_pos[0]   = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VW-1:0] w_left;
        logic [VW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        ole_cell #(
            .IDX (g),
            .CW  (CW),
            .IW  (IW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_pos     (w_pos),
            .i_count   (r_count),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_val     (w_val[g]),
            .i_tok     (w_tok[g]),
            .i_tok_pos (w_tok_pos[g]),
            .o_tok     (w_tok[g+1]),
            .o_tok_pos (w_tok_pos[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= n_count;
                        if (w_scan) begin
                            r_state   <= S_SCAN;
                            r_first   <= 1'b1;
                            r_is_find <= (w_mode == ole_pkg::MODE_FIND);
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= w_status;
                            r_out_data   <= '0;
                            r_out_fpos   <= '0;
                            r_out_count  <= n_count;
                        end
                    end
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    if (w_tok[DEPTH].valid) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_out_count <= r_count;
                        if (r_is_find) begin
                            r_out_data <= '0;
                            if (w_tok[DEPTH].found) begin
                                r_out_status <= ole_pkg::ST_OK;
                                r_out_fpos   <= w_tok_pos[DEPTH];
                            end else begin
                                r_out_status <= ole_pkg::ST_NOTFOUND;
                                r_out_fpos   <= '0;
                            end
                        end else begin
                            r_out_status <= ole_pkg::ST_OK;
                            r_out_data   <= w_tok[DEPTH].data;
                            r_out_fpos   <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = OUT_DW'({r_out_count, r_out_fpos, r_out_data});

endmodule

[sv/ole_checker.sv]
// Port-level checks for ordered_list_engine_core, bound to the top level.
// Depends on ole_pkg for status codes.
module ole_checker #(
    parameter int DEPTH = 16,
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int IW     = $clog2(DEPTH),
    localparam int VW     = ole_pkg::VAL_W,
    localparam int OUT_DW = ((VW + IW + CW + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tready,
    input logic              i_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_DW-1:0] i_m_tdata,
    input logic [1:0]        i_m_tuser
);

    logic [CW-1:0] w_count;
    logic [IW-1:0] w_fpos;

    assign w_count = i_m_tdata[VW+IW+CW-1:VW+IW];
    assign w_fpos  = i_m_tdata[VW+IW-1:VW];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result dropped or changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> w_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == ole_pkg::ST_FULL |-> w_count == CW'(DEPTH))
        else $error("full status with room left");

    a_fpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && w_fpos != '0 |->
            i_m_tuser == ole_pkg::ST_OK && w_count > CW'(w_fpos))
        else $error("found position without a matching entry");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tready && i_m_tvalid |-> i_m_tready)
        else $error("request taken while result blocks output");

endmodule

bind ordered_list_engine_core ole_checker #(
    .DEPTH (DEPTH)
) u_ole_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

[verif/tb.sv]
// Self-checking bench for ordered_list_engine_core: a table of directed requests, then
// random insert/read/delete/find traffic checked against an in-bench list model.
// Depends on ole_pkg and the RTL only.
module tb;

    localparam int DEPTH       = 16;
    localparam int IN_DW       = 40;
    localparam int OUT_DW      = 48;
    localparam int DIR_N       = 29;
    localparam int RAND_N      = 400;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 150;
    localparam int WATCHDOG    = 2000;

    typedef struct packed {
        ole_pkg::t_status status;
        logic [31:0]      read_value;
        logic [3:0]       found_pos;
        logic [4:0]       count;
    } t_list_result;

    typedef struct packed {
        ole_pkg::t_mode mode;
        logic [4:0]     pos;
        logic [31:0]    value;
        logic           typed;
        t_list_result   want;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_DW-1:0]  i_s_axis_tdata = '0;
    logic [1:0]        i_s_axis_tuser = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] o_m_axis_tdata;
    logic [1:0]        o_m_axis_tuser;

    logic [31:0]  list_mem [DEPTH];
    int           list_len = 0;
    t_list_result result_q [$];
    t_list_result want_r;
    int           fails = 0;
    int           results_seen = 0;
    int           hold_left = 0;
    int           idle_cycles = 0;
    bit           calm = 1'b0;

    t_dir_row dir_tab [DIR_N] = '{
        '{ole_pkg::MODE_READ,   5'd0,  32'h0000_0000, 1'b1,
          '{ole_pkg::ST_RANGE,    32'h0, 4'd0, 5'd0}},
        '{ole_pkg::MODE_DELETE, 5'd0,  32'h0000_0000, 1'b1,
          '{ole_pkg::ST_RANGE,    32'h0, 4'd0, 5'd0}},
        '{ole_pkg::MODE_FIND,   5'd0,  32'h0000_0000, 1'b1,
          '{ole_pkg::ST_NOTFOUND, 32'h0, 4'd0, 5'd0}},
        '{ole_pkg::MODE_INSERT, 5'd1,  32'h0000_0005, 1'b1,
          '{ole_pkg::ST_RANGE,    32'h0, 4'd0, 5'd0}},
        '{ole_pkg::MODE_INSERT, 5'd0,  32'h8000_0000, 1'b1,
          '{ole_pkg::ST_OK,       32'h0, 4'd0, 5'd1}},
        '{ole_pkg::MODE_READ,   5'd0,  32'h0000_0000, 1'b1,
          '{ole_pkg::ST_OK, 32'h8000_0000, 4'd0, 5'd1}},
        '{ole_pkg::MODE_INSERT, 5'd1,  32'h7fff_ffff, 1'b1,
          '{ole_pkg::ST_OK,       32'h0, 4'd0, 5'd2}},
        '{ole_pkg::MODE_FIND,   5'd0,  32'h7fff_ffff, 1'b1,
          '{ole_pkg::ST_OK,       32'h0, 4'd1, 5'd2}},
        '{ole_pkg::MODE_INSERT, 5'd1,  32'hffff_ffff, 1'b1,
          '{ole_pkg::ST_OK,       32'h0, 4'd0, 5'd3}},
        '{ole_pkg::MODE_INSERT, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd4,  32'h7fff_ffff, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd2,  32'h0000_0001, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd6,  32'hffff_fffe, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd1,  32'h0000_0001, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd8,  32'h8000_0001, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd3,  32'hdead_beef, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd10, 32'h5555_5555, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd5,  32'haaaa_aaaa, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd12, 32'h0000_ffff, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd7,  32'hffff_0000, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd14, 32'h7fff_fffe, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd15, 32'h8000_0000, 1'b0, '0},
        '{ole_pkg::MODE_INSERT, 5'd16, 32'h0000_0009, 1'b1,
          '{ole_pkg::ST_FULL,     32'h0, 4'd0, 5'd16}},
        '{ole_pkg::MODE_INSERT, 5'd17, 32'h0000_0009, 1'b1,
          '{ole_pkg::ST_RANGE,    32'h0, 4'd0, 5'd16}},
        '{ole_pkg::MODE_READ,   5'd15, 32'h0000_0000, 1'b0, '0},
        '{ole_pkg::MODE_DELETE, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{ole_pkg::MODE_DELETE, 5'd14, 32'h0000_0000, 1'b0, '0},
        '{ole_pkg::MODE_FIND,   5'd0,  32'h7fff_ffff, 1'b0, '0},
        '{ole_pkg::MODE_FIND,   5'd9,  32'h1234_5678, 1'b1,
          '{ole_pkg::ST_NOTFOUND, 32'h0, 4'd0, 5'd14}}
    };

    ordered_list_engine_core #(.DEPTH(DEPTH)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_list_result list_apply(ole_pkg::t_mode m, logic [4:0] p,
                                                logic [31:0] v);
        t_list_result r;
        int i;
        r = '0;
        case (m)
            ole_pkg::MODE_INSERT: begin
                if (p > list_len) begin
                    r.status = ole_pkg::ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    r.status = ole_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = v;
                    list_len++;
                end
            end
            ole_pkg::MODE_READ: begin
                if (p >= list_len) r.status = ole_pkg::ST_RANGE;
                else r.read_value = list_mem[p];
            end
            ole_pkg::MODE_DELETE: begin
                if (p >= list_len) begin
                    r.status = ole_pkg::ST_RANGE;
                end else begin
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            default: begin
                r.status = ole_pkg::ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (r.status == ole_pkg::ST_NOTFOUND && list_mem[i] == v) begin
                        r.status    = ole_pkg::ST_OK;
                        r.found_pos = 4'(i);
                    end
                end
            end
        endcase
        r.count = 5'(list_len);
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(ole_pkg::t_mode m, logic [4:0] p, logic [31:0] v,
                                logic typed, t_list_result want);
        t_list_result model_res;
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 10) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, v, p};
        i_s_axis_tuser  <= m;
        do @(posedge i_clk); while (!o_s_axis_tready);
        model_res = list_apply(m, p, v);
        result_q.push_back(typed ? want : model_res);
    endtask

    initial begin : stim
        int k;
        int wr;
        int ins_w;
        int del_w;
        bit bad;
        ole_pkg::t_mode m;
        logic [4:0] p;
        logic [31:0] v;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_N; k++) begin
            send_request(dir_tab[k].mode, dir_tab[k].pos, dir_tab[k].value,
                         dir_tab[k].typed, dir_tab[k].want);
        end

        // drain before random traffic
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (result_q.size() != 0);

        for (k = 0; k < RAND_N; k++) begin
            calm = (k >= 200 && k < 280);
            if (k == 120) begin
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (result_q.size() != 0);
            end
            case ((k / 50) % 3)
                0: begin ins_w = 55; del_w = 15; end
                1: begin ins_w = 15; del_w = 55; end
                default: begin ins_w = 30; del_w = 30; end
            endcase
            bad = ($urandom_range(0, 9) == 0);
            v = $urandom;
            if ($urandom_range(0, 99) < 4) begin
                m = ole_pkg::t_mode'($urandom_range(0, 3));
                p = 5'($urandom_range(0, 31));
            end else begin
                wr = $urandom_range(0, 99);
                if (wr < ins_w) begin
                    m = ole_pkg::MODE_INSERT;
                    p = bad ? 5'($urandom_range(list_len + 1, 31))
                            : 5'($urandom_range(0, list_len));
                    v = pick_value();
                end else if (wr < ins_w + del_w) begin
                    m = ole_pkg::MODE_DELETE;
                end else if (wr < ins_w + del_w + (100 - ins_w - del_w) / 2) begin
                    m = ole_pkg::MODE_READ;
                end else begin
                    m = ole_pkg::MODE_FIND;
                    p = 5'($urandom_range(0, 31));
                    if (list_len > 0 && $urandom_range(0, 99) < 60)
                        v = list_mem[$urandom_range(0, list_len - 1)];
                    else
                        v = pick_value();
                end
                if (m == ole_pkg::MODE_READ || m == ole_pkg::MODE_DELETE) begin
                    p = (bad || list_len == 0) ? 5'($urandom_range(list_len, 31))
                                               : 5'($urandom_range(0, list_len - 1));
                end
            end
            send_request(m, p, v, 1'b0, '0);
        end

        i_s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (result_q.size() != 0) fails++;
        if (fails == 0) begin
            $display("ordered_list_engine_core: match");
        end else begin
            $display("ordered_list_engine_core: mismatch");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (result_q.size() == 0) begin
                    $error("result with no request pending");
                    fails++;
                end else begin
                    want_r = result_q.pop_front();
                    if (o_m_axis_tuser !== want_r.status) begin
                        $error("status: expected %0d got %0d", want_r.status, o_m_axis_tuser);
                        fails++;
                    end
                    if (o_m_axis_tdata[31:0] !== want_r.read_value) begin
                        $error("read_value: expected %0h got %0h", want_r.read_value,
                               o_m_axis_tdata[31:0]);
                        fails++;
                    end
                    if (o_m_axis_tdata[35:32] !== want_r.found_pos) begin
                        $error("found_position: expected %0d got %0d", want_r.found_pos,
                               o_m_axis_tdata[35:32]);
                        fails++;
                    end
                    if (o_m_axis_tdata[40:36] !== want_r.count) begin
                        $error("entry_count: expected %0d got %0d", want_r.count,
                               o_m_axis_tdata[40:36]);
                        fails++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            // hold off the result side to back up the request side
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("ordered_list_engine_core: mismatch");
                $finish;
            end
        end
    end

endmodule
